>>> src/ibpd_pkg.sv
// Shared types, constants and register map of the infrared beacon pulse decoder.
package ibpd_pkg;

    localparam int STAMP_W = 16;
    localparam int CODE_W = 7;
    localparam int SLOT_W = 2;
    localparam int NUM_CODES = 4;

    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W = 3;

    localparam int FRAME_BITS_DEF = 7;
    localparam int ABORT_WIDTH_DEF = 300;

    localparam logic [REG_IDX_W-1:0] REG_CODE_LEFT      = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_CODE_MID_LEFT  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_CODE_RIGHT     = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_CODE_MID_RIGHT = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_HEADER_MIN     = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_HEADER_MAX     = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_ONE_MIN        = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_ONE_MAX        = 3'd7;

    localparam logic [STAMP_W-1:0] HEADER_MIN_RST = 16'd370;
    localparam logic [STAMP_W-1:0] HEADER_MAX_RST = 16'd550;
    localparam logic [STAMP_W-1:0] ONE_MIN_RST    = 16'd100;
    localparam logic [STAMP_W-1:0] ONE_MAX_RST    = 16'd210;

    typedef struct packed {
        logic [NUM_CODES-1:0][CODE_W-1:0] codes;
        logic [STAMP_W-1:0]               header_min;
        logic [STAMP_W-1:0]               header_max;
        logic [STAMP_W-1:0]               one_min;
        logic [STAMP_W-1:0]               one_max;
    } cfg_t;

    typedef struct packed {
        logic header_hit;
        logic one_hit;
        logic abort_hit;
    } pulse_class_t;

endpackage

>>> src/ibpd_regs.sv
// APB configuration register file holding beacon codes and pulse windows.
module ibpd_regs (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [ibpd_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [ibpd_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [ibpd_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready,
    output ibpd_pkg::cfg_t                    cfg
);

    ibpd_pkg::cfg_t                      cfg_reg;
    logic [ibpd_pkg::REG_IDX_W-1:0]      reg_idx;
    logic                                wr_en;

    assign reg_idx = paddr[ibpd_pkg::APB_ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.codes      <= '0;
            cfg_reg.header_min <= ibpd_pkg::HEADER_MIN_RST;
            cfg_reg.header_max <= ibpd_pkg::HEADER_MAX_RST;
            cfg_reg.one_min    <= ibpd_pkg::ONE_MIN_RST;
            cfg_reg.one_max    <= ibpd_pkg::ONE_MAX_RST;
        end else if (wr_en) begin
            unique case (reg_idx)
                ibpd_pkg::REG_CODE_LEFT:
                    cfg_reg.codes[0] <= pwdata[ibpd_pkg::CODE_W-1:0];
                ibpd_pkg::REG_CODE_MID_LEFT:
                    cfg_reg.codes[1] <= pwdata[ibpd_pkg::CODE_W-1:0];
                ibpd_pkg::REG_CODE_RIGHT:
                    cfg_reg.codes[2] <= pwdata[ibpd_pkg::CODE_W-1:0];
                ibpd_pkg::REG_CODE_MID_RIGHT:
                    cfg_reg.codes[3] <= pwdata[ibpd_pkg::CODE_W-1:0];
                ibpd_pkg::REG_HEADER_MIN:
                    cfg_reg.header_min <= pwdata[ibpd_pkg::STAMP_W-1:0];
                ibpd_pkg::REG_HEADER_MAX:
                    cfg_reg.header_max <= pwdata[ibpd_pkg::STAMP_W-1:0];
                ibpd_pkg::REG_ONE_MIN:
                    cfg_reg.one_min <= pwdata[ibpd_pkg::STAMP_W-1:0];
                ibpd_pkg::REG_ONE_MAX:
                    cfg_reg.one_max <= pwdata[ibpd_pkg::STAMP_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (reg_idx)
            ibpd_pkg::REG_CODE_LEFT:
                prdata = ibpd_pkg::APB_DATA_W'(cfg_reg.codes[0]);
            ibpd_pkg::REG_CODE_MID_LEFT:
                prdata = ibpd_pkg::APB_DATA_W'(cfg_reg.codes[1]);
            ibpd_pkg::REG_CODE_RIGHT:
                prdata = ibpd_pkg::APB_DATA_W'(cfg_reg.codes[2]);
            ibpd_pkg::REG_CODE_MID_RIGHT:
                prdata = ibpd_pkg::APB_DATA_W'(cfg_reg.codes[3]);
            ibpd_pkg::REG_HEADER_MIN:
                prdata = ibpd_pkg::APB_DATA_W'(cfg_reg.header_min);
            ibpd_pkg::REG_HEADER_MAX:
                prdata = ibpd_pkg::APB_DATA_W'(cfg_reg.header_max);
            ibpd_pkg::REG_ONE_MIN:
                prdata = ibpd_pkg::APB_DATA_W'(cfg_reg.one_min);
            ibpd_pkg::REG_ONE_MAX:
                prdata = ibpd_pkg::APB_DATA_W'(cfg_reg.one_max);
            default: prdata = '0;
        endcase
    end

endmodule

>>> src/ibpd_classify.sv
// Pulse width measurement with wraparound and window classification.
module ibpd_classify #(
    parameter int ABORT_WIDTH = ibpd_pkg::ABORT_WIDTH_DEF
) (
    input  logic [ibpd_pkg::STAMP_W-1:0] stamp,
    input  logic [ibpd_pkg::STAMP_W-1:0] rise_time,
    input  ibpd_pkg::cfg_t               cfg,
    output ibpd_pkg::pulse_class_t       pclass
);

    logic [ibpd_pkg::STAMP_W-1:0] diff;
    logic [ibpd_pkg::STAMP_W-1:0] width;
    logic                         wrapped;

    // The stamp wraps after 65534, so a wrapped pulse is one tick shorter than the raw difference.
    assign wrapped = stamp < rise_time;
    assign diff    = stamp - rise_time;
    assign width   = diff - ibpd_pkg::STAMP_W'(wrapped);

    assign pclass.header_hit = (width >= cfg.header_min) && (width < cfg.header_max);
    assign pclass.one_hit    = (width >= cfg.one_min) && (width < cfg.one_max);
    assign pclass.abort_hit  = width >= ibpd_pkg::STAMP_W'(ABORT_WIDTH);

endmodule

>>> src/ibpd_match.sv
// Priority match of a received code against the four configured beacon codes.
module ibpd_match (
    input  logic [ibpd_pkg::CODE_W-1:0] code,
    input  ibpd_pkg::cfg_t              cfg,
    output logic                        matched,
    output logic [ibpd_pkg::SLOT_W-1:0] slot
);

    always_comb begin
        matched = 1'b0;
        slot    = '0;
        for (int k = ibpd_pkg::NUM_CODES - 1; k >= 0; k--) begin
            if (code == cfg.codes[k]) begin
                matched = 1'b1;
                slot    = ibpd_pkg::SLOT_W'(k);
            end
        end
    end

endmodule

>>> src/ir_beacon_pulse_decoder.sv
// Infrared beacon pulse decoder: edge beats in, one code beat out per received frame.
// A frame's final falling-edge beat goes from the input register to the result registers.
// Throughput: one edge beat per cycle, set by the single decode stage after the input register.
// The decode stage holds only while an undelivered result waits and m_ready is low.
// Reset (aresetn low, synchronous) clears the receive state, both valid flags and the
// configuration registers to their default windows and zero codes.
module ir_beacon_pulse_decoder #(
    parameter int FRAME_BITS  = ibpd_pkg::FRAME_BITS_DEF,
    parameter int ABORT_WIDTH = ibpd_pkg::ABORT_WIDTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_level,
    input  logic [ibpd_pkg::STAMP_W-1:0]      s_stamp,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [ibpd_pkg::CODE_W-1:0]       m_code,
    output logic                              m_matched,
    output logic [ibpd_pkg::SLOT_W-1:0]       m_slot,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [ibpd_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [ibpd_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [ibpd_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready
);

    localparam int CNT_W = (FRAME_BITS > 1) ? $clog2(FRAME_BITS) : 1;
    localparam int EXT_W = (FRAME_BITS > ibpd_pkg::CODE_W) ? FRAME_BITS : ibpd_pkg::CODE_W;

    ibpd_pkg::cfg_t               cfg;
    ibpd_pkg::pulse_class_t       pclass;

    logic                         in_valid_reg;
    logic                         level_reg;
    logic [ibpd_pkg::STAMP_W-1:0] stamp_reg;
    logic                         advance;

    logic                         in_pulse_reg, in_pulse_next;
    logic                         header_seen_reg, header_seen_next;
    logic [ibpd_pkg::STAMP_W-1:0] rise_time_reg, rise_time_next;
    logic [CNT_W-1:0]             bit_count_reg, bit_count_next;
    logic [FRAME_BITS-1:0]        shift_reg, shift_next;

    logic [FRAME_BITS-1:0]        shift_bit;
    logic [ibpd_pkg::CODE_W-1:0]  frame_code;
    logic                         last_bit;
    logic                         emit;
    logic                         match_hit;
    logic [ibpd_pkg::SLOT_W-1:0]  match_slot;

    logic                         m_valid_reg;
    logic [ibpd_pkg::CODE_W-1:0]  m_code_reg;
    logic                         m_matched_reg;
    logic [ibpd_pkg::SLOT_W-1:0]  m_slot_reg;

    ibpd_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ibpd_classify #(
        .ABORT_WIDTH (ABORT_WIDTH)
    ) u_classify (
        .stamp     (stamp_reg),
        .rise_time (rise_time_reg),
        .cfg       (cfg),
        .pclass    (pclass)
    );

    assign advance = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            level_reg <= s_level;
            stamp_reg <= s_stamp;
        end
    end

    assign shift_bit  = pclass.one_hit ? (shift_reg | FRAME_BITS'(1)) : shift_reg;
    assign last_bit   = bit_count_reg == CNT_W'(FRAME_BITS - 1);
    assign frame_code = ibpd_pkg::CODE_W'(EXT_W'(shift_bit));

    ibpd_match u_match (
        .code    (frame_code),
        .cfg     (cfg),
        .matched (match_hit),
        .slot    (match_slot)
    );

    always_comb begin
        in_pulse_next    = in_pulse_reg;
        header_seen_next = header_seen_reg;
        rise_time_next   = rise_time_reg;
        bit_count_next   = bit_count_reg;
        shift_next       = shift_reg;
        emit             = 1'b0;
        if (advance) begin
            if (!in_pulse_reg) begin
                if (level_reg) begin
                    rise_time_next = stamp_reg;
                    in_pulse_next  = 1'b1;
                end
            end else if (!level_reg) begin
                in_pulse_next = 1'b0;
                if (!header_seen_reg) begin
                    if (pclass.header_hit) begin
                        header_seen_next = 1'b1;
                        bit_count_next   = '0;
                        shift_next       = '0;
                    end
                end else if (pclass.one_hit || !pclass.abort_hit) begin
                    if (last_bit) begin
                        emit             = 1'b1;
                        header_seen_next = 1'b0;
                        bit_count_next   = '0;
                        shift_next       = '0;
                    end else begin
                        bit_count_next = bit_count_reg + CNT_W'(1);
                        shift_next     = shift_bit << 1;
                    end
                end else begin
                    header_seen_next = 1'b0;
                    bit_count_next   = '0;
                    shift_next       = '0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_pulse_reg    <= 1'b0;
            header_seen_reg <= 1'b0;
            rise_time_reg   <= '0;
            bit_count_reg   <= '0;
            shift_reg       <= '0;
        end else begin
            in_pulse_reg    <= in_pulse_next;
            header_seen_reg <= header_seen_next;
            rise_time_reg   <= rise_time_next;
            bit_count_reg   <= bit_count_next;
            shift_reg       <= shift_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_code_reg    <= frame_code;
            m_matched_reg <= match_hit;
            m_slot_reg    <= match_slot;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_code    = m_code_reg;
    assign m_matched = m_matched_reg;
    assign m_slot    = m_slot_reg;

endmodule

>>> src/ibpd_checker.sv
// Port-level checker for the infrared beacon pulse decoder and its bind.
module ibpd_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_valid,
    input logic                              s_ready,
    input logic                              m_valid,
    input logic                              m_ready,
    input logic [ibpd_pkg::CODE_W-1:0]       m_code,
    input logic                              m_matched,
    input logic [ibpd_pkg::SLOT_W-1:0]       m_slot,
    input logic                              pready
);

    // A rising result beat must be preceded by an accepted edge beat.
    a_result_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready, 2))
        else $error("result beat without an edge beat two cycles before");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_code) && $stable(m_matched)
                                && $stable(m_slot))
        else $error("stalled result beat changed");

    a_slot_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_matched |-> m_slot == '0)
        else $error("unmatched code reports a nonzero slot");

    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_pready: assert property (@(posedge aclk) disable iff (!aresetn)
        pready)
        else $error("configuration port inserted a wait state");

endmodule

bind ir_beacon_pulse_decoder ibpd_checker u_ibpd_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_valid   (s_valid),
    .s_ready   (s_ready),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_code    (m_code),
    .m_matched (m_matched),
    .m_slot    (m_slot),
    .pready    (pready)
);
